FILE: sv/bnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-N text decoder package
// Shared widths, codes, the result bundle type and the alphabet lookup.
// ----------------------------------------------------------------------------
package bnd_pkg;

    localparam int ACC_W   = 40;
    localparam int HELD_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int BYTE_W  = 8;
    localparam int VAL_W   = 6;
    localparam int SW_W    = 3;
    localparam int MAX_RES = 5;
    localparam int CNT_W   = 3;
    localparam int IDX_W   = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;

    localparam logic [HELD_W-1:0] HELD_MAX = 6'd44;
    localparam logic [HELD_W-1:0] PAD_SAT  = 6'd63;
    localparam logic [CNT_W-1:0]  RES_MAX  = 3'd5;

    localparam logic [1:0] MODE_B16     = 2'd0;
    localparam logic [1:0] MODE_B32     = 2'd1;
    localparam logic [1:0] MODE_B64     = 2'd2;
    localparam logic [1:0] MODE_B64_ALT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_WS  = 1'b1;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D;

    typedef enum logic {
        OP_DECODE = 1'b0,
        OP_FINISH = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_BAD_SYMBOL   = 3'd1,
        ERR_BAD_PAD      = 3'd2,
        ERR_PAD_OVERFLOW = 3'd3,
        ERR_BAD_WIDTH    = 3'd4,
        ERR_NONZERO_TAIL = 3'd5
    } t_err;

    // One input's worth of results: cnt bytes, or a single error result.
    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        t_err                            err;
        logic [MAX_RES-1:0][BYTE_W-1:0]  bytes;
    } t_bundle;

    function automatic logic [SW_W-1:0] sym_width(input logic [1:0] mode);
        logic [SW_W-1:0] w;
        unique case (mode)
            MODE_B16: w = 3'd4;
            MODE_B32: w = 3'd5;
            default:  w = 3'd6;
        endcase
        return w;
    endfunction

    function automatic logic [HELD_W-1:0] quantum_width(input logic [1:0] mode);
        logic [HELD_W-1:0] q;
        unique case (mode)
            MODE_B16: q = 6'd8;
            MODE_B32: q = 6'd40;
            default:  q = 6'd24;
        endcase
        return q;
    endfunction

    // Returns {bad, value}.
    function automatic logic [VAL_W:0] sym_lookup(input logic [1:0] mode,
                                                  input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        logic              bad;
        d   = '0;
        bad = 1'b0;
        unique case (mode)
            MODE_B16: begin
                if (c >= 8'h30 && c <= 8'h39) begin
                    d = c - 8'h30;
                end else if (c >= 8'h41 && c <= 8'h46) begin
                    d = c - 8'h41 + 8'd10;
                end else begin
                    bad = 1'b1;
                end
            end
            MODE_B32: begin
                if (c >= 8'h41 && c <= 8'h5A) begin
                    d = c - 8'h41;
                end else if (c >= 8'h32 && c <= 8'h37) begin
                    d = c - 8'h32 + 8'd26;
                end else begin
                    bad = 1'b1;
                end
            end
            default: begin
                if (c >= 8'h41 && c <= 8'h5A) begin
                    d = c - 8'h41;
                end else if (c >= 8'h61 && c <= 8'h7A) begin
                    d = c - 8'h61 + 8'd26;
                end else if (c >= 8'h30 && c <= 8'h39) begin
                    d = c - 8'h30 + 8'd52;
                end else if (c == 8'h2B) begin
                    d = 8'd62;
                end else if (c == 8'h2F) begin
                    d = 8'd63;
                end else begin
                    bad = 1'b1;
                end
            end
        endcase
        return {bad, d[VAL_W-1:0]};
    endfunction

    // True when x is a multiple of the quantum; x stays below three quanta
    // whenever the padding is below one quantum.
    function automatic logic quantum_aligned(input logic [HELD_W:0] x,
                                             input logic [1:0] mode);
        logic [HELD_W:0] q;
        logic [HELD_W:0] r;
        q = {1'b0, quantum_width(mode)};
        r = x;
        if (mode == MODE_B16) begin
            return (x[2:0] == 3'd0);
        end
        if (r >= {q[HELD_W-1:0], 1'b0}) begin
            r = r - {q[HELD_W-1:0], 1'b0};
        end else if (r >= q) begin
            r = r - q;
        end
        return (r == '0);
    endfunction

endpackage

FILE: sv/bnd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-N decoder input channel
// Valid/ready channel carrying one opcode and one character per request.
// ----------------------------------------------------------------------------
interface bnd_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] symbol;

    modport source (output valid, output opcode, output symbol, input ready);
    modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

FILE: sv/bnd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-N decoder output channel
// Valid/ready channel carrying one decoded byte or one error per request.
// ----------------------------------------------------------------------------
interface bnd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic [2:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output has_byte,
                    output error_code, output last, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input error_code, input last, output ready);
endinterface

FILE: sv/bnd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-N decoder core
// Input register, bit accumulator state and single-pass decode of one request
// into a bundle of up to five bytes or one error.
// ----------------------------------------------------------------------------
module bnd_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_alphabet_mode,
    input  logic              i_skip_ws,
    bnd_in_if.sink            i_in,
    input  logic              i_bundle_free,
    output logic              o_load,
    output bnd_pkg::t_bundle  o_bundle
);
    import bnd_pkg::*;

    logic                r_in_valid;
    t_op                 r_in_op;
    logic [CHAR_W-1:0]   r_in_sym;
    logic [ACC_W-1:0]    r_acc;
    logic [HELD_W-1:0]   r_held;
    logic [HELD_W-1:0]   r_pad;
    logic [ACC_W-1:0]    n_acc;
    logic [HELD_W-1:0]   n_held;
    logic [HELD_W-1:0]   n_pad;

    logic                fire;
    logic [1:0]          mode;
    logic [SW_W-1:0]     sw;
    logic [HELD_W-1:0]   qw;
    logic [VAL_W:0]      lookup;
    logic [VAL_W-1:0]    val;
    logic                is_ws;
    logic [HELD_W:0]     pad_sum;
    logic [HELD_W:0]     held_pad;
    logic [BYTE_W-1:0]   tail_mask;
    logic [CNT_W-1:0]    n_flush;
    logic [HELD_W-1:0]   held_base;
    logic [ACC_W-1:0]    acc_shifted;
    logic [MAX_RES-1:0][BYTE_W-1:0] flush_bytes;
    t_err                err;
    logic [CNT_W-1:0]    cnt;

    assign fire        = r_in_valid && i_bundle_free;
    assign i_in.ready  = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_op  <= t_op'(i_in.opcode);
            r_in_sym <= i_in.symbol;
        end
    end

    assign mode     = (i_alphabet_mode == MODE_B64_ALT) ? MODE_B64 : i_alphabet_mode;
    assign sw       = sym_width(mode);
    assign qw       = quantum_width(mode);
    assign lookup   = sym_lookup(mode, r_in_sym);
    assign val      = lookup[VAL_W-1:0];
    assign is_ws    = (r_in_sym == CH_SPACE) || (r_in_sym == CH_TAB) ||
                      (r_in_sym == CH_CR) || (r_in_sym == CH_LF);
    assign pad_sum  = {1'b0, r_pad} + {{(HELD_W+1-SW_W){1'b0}}, sw};
    assign held_pad = {1'b0, r_held} + {1'b0, r_pad};
    assign tail_mask = ~(8'hFF << r_held[2:0]);
    assign n_flush  = (r_held[HELD_W-1:3] > RES_MAX) ? RES_MAX : r_held[HELD_W-1:3];
    assign held_base = r_held - {n_flush, 3'b000};

    // Bytes leave most significant first; byte k sits 8*(k+1) bits below the top.
    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            logic [HELD_W-1:0] amt;
            logic [ACC_W-1:0]  sh;
            amt = r_held - HELD_W'((k + 1) * BYTE_W);
            sh  = r_acc >> amt;
            flush_bytes[k] = sh[BYTE_W-1:0];
        end
    end

    always_comb begin
        logic [HELD_W-1:0] base;
        base = (r_held >= qw) ? held_base : r_held;
        unique case (mode)
            MODE_B16: acc_shifted = {r_acc[ACC_W-5:0], val[3:0]};
            MODE_B32: acc_shifted = {r_acc[ACC_W-6:0], val[4:0]};
            default:  acc_shifted = {r_acc[ACC_W-7:0], val};
        endcase
        n_acc  = r_acc;
        n_held = r_held;
        n_pad  = r_pad;
        err    = ERR_NONE;
        cnt    = '0;
        if (fire) begin
            if (r_in_op == OP_DECODE) begin
                priority if (i_skip_ws && is_ws) begin
                    n_pad = r_pad;
                end else if (r_in_sym == CH_PAD) begin
                    n_pad = (pad_sum > {1'b0, PAD_SAT}) ? PAD_SAT : pad_sum[HELD_W-1:0];
                end else if (r_pad != '0) begin
                    err = ERR_BAD_PAD;
                end else if (lookup[VAL_W]) begin
                    err = ERR_BAD_SYMBOL;
                end else begin
                    if (r_held >= qw) begin
                        cnt = n_flush;
                    end
                    n_acc  = acc_shifted;
                    n_held = base + {{(HELD_W-SW_W){1'b0}}, sw};
                end
            end else begin
                priority if (r_pad >= qw) begin
                    err = ERR_PAD_OVERFLOW;
                end else if (!quantum_aligned(held_pad, mode)) begin
                    err = ERR_BAD_WIDTH;
                end else if ((r_acc[BYTE_W-1:0] & tail_mask) != '0) begin
                    err = ERR_NONZERO_TAIL;
                end else if (r_held[2:0] >= sw) begin
                    err = ERR_BAD_PAD;
                end else begin
                    cnt    = n_flush;
                    n_acc  = '0;
                    n_held = '0;
                    n_pad  = '0;
                end
            end
            if (err != ERR_NONE) begin
                cnt    = 3'd1;
                n_acc  = '0;
                n_held = '0;
                n_pad  = '0;
            end
        end
    end

    assign o_load         = fire && (cnt != '0);
    assign o_bundle.cnt   = cnt;
    assign o_bundle.err   = err;
    assign o_bundle.bytes = flush_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_held <= '0;
            r_pad  <= '0;
        end else begin
            r_acc  <= n_acc;
            r_held <= n_held;
            r_pad  <= n_pad;
        end
    end

    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_MAX)
        else $error("held bit count out of range");

    a_error_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (err != ERR_NONE) |=> (r_held == '0) && (r_pad == '0) && (r_acc == '0))
        else $error("state not cleared after an error");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !i_bundle_free |=> r_in_valid && $stable(r_in_sym) && $stable(r_held))
        else $error("stalled request lost or state moved");

endmodule

FILE: sv/bnd_burst.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-N decoder result burst register
// Holds one result bundle and hands its results out one per request.
// ----------------------------------------------------------------------------
module bnd_burst (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bnd_pkg::t_bundle  i_bundle,
    output logic              o_free,
    bnd_out_if.source         o_out
);
    import bnd_pkg::*;

    logic              r_valid;
    logic [IDX_W-1:0]  r_idx;
    t_bundle           r_bundle;
    logic              last_item;
    logic              take;

    assign last_item = (r_idx == (r_bundle.cnt - 3'd1));
    assign take      = r_valid && o_out.ready;
    assign o_free    = !r_valid || (take && last_item);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (take) begin
            if (last_item) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.has_byte   = (r_bundle.err == ERR_NONE);
    assign o_out.out_byte   = (r_bundle.err == ERR_NONE) ? r_bundle.bytes[r_idx] : '0;
    assign o_out.error_code = r_bundle.err;
    assign o_out.last       = last_item;

    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_bundle.cnt != '0) && (r_idx < r_bundle.cnt))
        else $error("burst index outside the bundle");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_bundle.err != ERR_NONE) |-> (r_bundle.cnt == 3'd1))
        else $error("error bundle with more than one result");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("bundle loaded over pending results");

endmodule

FILE: sv/base_n_text_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Base-N text decoder top level
// Streaming Base16/Base32/Base64 decoder with a plain configuration port.
// ----------------------------------------------------------------------------
// One request (a character or a finish) is accepted per cycle while the
// burst register can take its results. Each request passes through an input
// register and one decode stage that updates the bit accumulator, then its
// results (up to five bytes, or one error) sit in a burst register that hands
// out one result per cycle while the output side is ready. A request with
// several results holds the burst register until its last result is taken;
// requests that yield none or one flow at full rate when the output is ready.
module base_n_text_decoder_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bnd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bnd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bnd_in_if.sink                          i_in,
    bnd_out_if.source                       o_out
);
    import bnd_pkg::*;

    logic [1:0] r_alphabet_mode;
    logic       r_skip_ws;
    logic       bundle_free;
    logic       bundle_load;
    t_bundle    bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_mode <= MODE_B64;
            r_skip_ws       <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALPHABET: r_alphabet_mode <= i_cfg_data;
                CFG_SKIP_WS:  r_skip_ws       <= i_cfg_data[0];
            endcase
        end
    end

    bnd_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_alphabet_mode (r_alphabet_mode),
        .i_skip_ws       (r_skip_ws),
        .i_in            (i_in),
        .i_bundle_free   (bundle_free),
        .o_load          (bundle_load),
        .o_bundle        (bundle)
    );

    bnd_burst u_burst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (bundle_load),
        .i_bundle (bundle),
        .o_free   (bundle_free),
        .o_out    (o_out)
    );

endmodule
